// ===== hw/rtl/bra_pkg.sv =====
// Shared constants, opcodes and types of the bitmap run allocator.
package bra_pkg;

  // Default bitmap size in bytes
  localparam int unsigned MAX_BYTES_DEF = 128;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BIT_W   = 10;
  localparam int unsigned RUN_W   = 11;
  localparam int unsigned MAP_W   = 8;
  localparam int unsigned LANE_W  = 3;
  localparam int unsigned LANES   = 8;

  // Reset value of the map length register
  localparam logic [MAP_W-1:0] MAP_BYTES_RST = 8'd128;

  // Runs starting at or beyond this bit cannot be reported
  localparam int unsigned START_LIMIT = 1024;

  // Opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd3;

  // Outcome of one byte pass of the run counter
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
    logic [RUN_W-1:0]  run;
  } step_res_t;

endpackage

// ===== hw/rtl/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: sequencer, config register, results.
//
// Command channel: an operation is taken at a clock edge with start_i high and
// busy_o low. opcode_i selects clear, test, write or first-fit scan; the other
// fields travel with it. map_bytes_we_i writes map_bytes_i into the map length
// register (bytes in use, clamped to MAX_BYTES); write it only while idle.
// Result channel: done_o is high for exactly one cycle with test_bit_o,
// found_o, start_index_o and index_error_o valid in that cycle. The receiver
// cannot stall; every command yields exactly one result beat.
// Test and write read the addressed byte, then answer or write it back;
// an out-of-range index is answered straight from idle. Clear and a scan
// walk the store one byte per cycle over L, the bytes in use. Empty maps
// and zero-length scans are answered from idle, without touching the store.
// busy_o stays high for the whole operation, so one command runs at a time.
// After reset the store is zeroed by a sweep over all MAX_BYTES bytes, one
// byte a cycle, with busy_o high; the map length register resets to 128.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             map_bytes_we_i,
  input  logic [MAP_W-1:0] map_bytes_i,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [BIT_W-1:0] bit_index_i,
  input  logic             bit_value_i,
  input  logic [RUN_W-1:0] run_length_i,
  output logic             done_o,
  output logic             test_bit_o,
  output logic             found_o,
  output logic [BIT_W-1:0] start_index_o,
  output logic             index_error_o
);

  localparam int unsigned AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CW  = $clog2(MAX_BYTES + 1);
  localparam int unsigned PW  = AW + LANE_W;
  localparam int unsigned SW  = ((PW > RUN_W) ? PW : RUN_W) + 1;

  // Sequencer states
  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic               vld_q, vld_d;
  logic [AW-1:0]      didx_q, didx_d;
  logic [AW-1:0]      hit_byte_q, hit_byte_d;
  logic [LANE_W-1:0]  hit_lane_q, hit_lane_d;
  logic [MAP_W-1:0]   map_bytes_q;

  logic [OP_W-1:0]    op_q;
  logic [BIT_W-1:0]   idx_q;
  logic               val_q;
  logic [RUN_W-1:0]   need_q;

  logic               done_q, done_d;
  logic               test_bit_q, test_bit_d;
  logic               found_q, found_d;
  logic [BIT_W-1:0]   start_q, start_d;
  logic               err_q, err_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  logic               accept;
  logic [MAP_W-1:0]   len;
  logic [RUN_W-1:0]   nbits;
  logic               idx_ok;
  logic [31:0]        idx_byte_in;
  logic [31:0]        idx_byte_q;
  logic [AW-1:0]      addr_in;
  logic [AW-1:0]      addr_q;
  logic [SW-1:0]      run_start;
  logic [7:0]         wr_byte;
  step_res_t          step;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Bytes in use, clamped to the store size
  assign len   = (32'(map_bytes_q) < MAX_BYTES) ? map_bytes_q : MAP_W'(MAX_BYTES);
  assign nbits = {len, 3'b000};
  assign idx_ok = ({1'b0, bit_index_i} < nbits);

  // Byte addresses of the indexed bit
  assign idx_byte_in = 32'(bit_index_i[BIT_W-1:LANE_W]);
  assign idx_byte_q  = 32'(idx_q[BIT_W-1:LANE_W]);
  assign addr_in     = idx_byte_in[AW-1:0];
  assign addr_q      = idx_byte_q[AW-1:0];

  // First bit of the found run, from the hit position and run length
  assign run_start = SW'({hit_byte_q, hit_lane_q}) + SW'(1) - SW'(need_q);

  // Byte with the addressed bit replaced
  always_comb begin
    wr_byte = mem_rdata;
    wr_byte[idx_q[LANE_W-1:0]] = val_q;
  end

  bra_mem #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bra_run_step u_step (
    .byte_i (mem_rdata),
    .run_i  (run_q),
    .need_i (need_q),
    .res_o  (step)
  );

  // Sequence the store port
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    vld_d      = 1'b0;
    didx_d     = didx_q;
    hit_byte_d = hit_byte_q;
    hit_lane_d = hit_lane_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[AW-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = cnt_q[AW-1:0];
    done_d     = 1'b0;
    test_bit_d = test_bit_q;
    found_d    = found_q;
    start_d    = start_q;
    err_d      = err_q;
    case (state_q)
      S_INIT: begin
        // Zero the store one byte a cycle
        mem_we = 1'b1;
        if (cnt_q == CW'(MAX_BYTES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          test_bit_d = 1'b0;
          found_d    = 1'b0;
          start_d    = '0;
          err_d      = 1'b0;
          case (opcode_i)
            OP_CLEAR: begin
              if (len == '0) begin
                done_d = 1'b1;
              end else begin
                cnt_d   = '0;
                state_d = S_CLEAR;
              end
            end
            OP_TEST, OP_WRITE: begin
              if (!idx_ok) begin
                err_d  = 1'b1;
                done_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = addr_in;
                state_d   = S_MODIFY;
              end
            end
            default: begin
              if ((run_length_i == '0) || (len == '0)) begin
                done_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                vld_d     = 1'b1;
                didx_d    = '0;
                cnt_d     = CW'(1);
                run_d     = '0;
                state_d   = S_SCAN;
              end
            end
          endcase
        end
      end
      S_CLEAR: begin
        // Zero the bytes in use
        mem_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        if (32'(cnt_q) + 32'd1 >= 32'(len)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MODIFY: begin
        // Answer the test or write the byte back
        if (op_q == OP_TEST) begin
          test_bit_d = mem_rdata[idx_q[LANE_W-1:0]];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          mem_wdata = wr_byte;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (vld_q) begin
          if (step.hit) begin
            hit_byte_d = didx_q;
            hit_lane_d = step.lane;
            state_d    = S_FINISH;
          end else begin
            run_d = step.run;
            // Prefetch the next byte while any remain
            if (32'(cnt_q) < 32'(len)) begin
              mem_re    = 1'b1;
              mem_raddr = cnt_q[AW-1:0];
              vld_d     = 1'b1;
              didx_d    = cnt_q[AW-1:0];
              cnt_d     = cnt_q + CW'(1);
            end
          end
        end else begin
          // End of map without a run
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FINISH: begin
        if (run_start < SW'(START_LIMIT)) begin
          found_d = 1'b1;
          start_d = run_start[BIT_W-1:0];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      run_q      <= '0;
      vld_q      <= 1'b0;
      didx_q     <= '0;
      hit_byte_q <= '0;
      hit_lane_q <= '0;
      done_q     <= 1'b0;
      test_bit_q <= 1'b0;
      found_q    <= 1'b0;
      start_q    <= '0;
      err_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      run_q      <= run_d;
      vld_q      <= vld_d;
      didx_q     <= didx_d;
      hit_byte_q <= hit_byte_d;
      hit_lane_q <= hit_lane_d;
      done_q     <= done_d;
      test_bit_q <= test_bit_d;
      found_q    <= found_d;
      start_q    <= start_d;
      err_q      <= err_d;
    end
  end

  // Map length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bytes_q <= MAP_BYTES_RST;
    end else if (map_bytes_we_i) begin
      map_bytes_q <= map_bytes_i;
    end
  end

  // Hold the command beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      idx_q  <= bit_index_i;
      val_q  <= bit_value_i;
      need_q <= run_length_i;
    end
  end

  assign done_o        = done_q;
  assign test_bit_o    = test_bit_q;
  assign found_o       = found_q;
  assign start_index_o = start_q;
  assign index_error_o = err_q;

endmodule

// ===== hw/rtl/bra_mem.sv =====
// Bitmap byte store: one write port and one registered read port.
module bra_mem
  import bra_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_BYTES_DEF,
  parameter int unsigned AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write one byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one byte, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bra_run_step.sv =====
// Free-run counter: advances the run count over the eight bits of one byte.
module bra_run_step
  import bra_pkg::*;
(
  input  logic [7:0]       byte_i,
  input  logic [RUN_W-1:0] run_i,
  input  logic [RUN_W-1:0] need_i,
  output step_res_t        res_o
);

  logic [RUN_W-1:0]  run;
  logic              hit;
  logic [LANE_W-1:0] lane;

  // Walk the bits LSB first; stop counting at the first complete run
  always_comb begin
    run  = run_i;
    hit  = 1'b0;
    lane = '0;
    for (int j = 0; j < LANES; j++) begin
      if (!hit) begin
        if (byte_i[j]) begin
          run = '0;
        end else begin
          run = run + RUN_W'(1);
          if (run == need_i) begin
            hit  = 1'b1;
            lane = LANE_W'(j);
          end
        end
      end
    end
  end

  assign res_o.hit  = hit;
  assign res_o.lane = lane;
  assign res_o.run  = run;

endmodule
